// ===== design/ntx_pkg.sv =====
package ntx_pkg;

    // APB register map
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [1:0] REG_BASE_UID        = 2'd0;
    localparam logic [1:0] REG_FORGET_INTERVAL = 2'd1;
    localparam logic [1:0] REG_NEAR_THRESHOLD  = 2'd2;

    localparam logic [7:0]  RST_BASE_UID        = 8'd0;
    localparam logic [31:0] RST_FORGET_INTERVAL = 32'd64;
    localparam logic [7:0]  RST_NEAR_THRESHOLD  = 8'd100;

    // word kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_MSG  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;
    localparam logic [1:0] ST_SWEPT    = 2'd3;

    localparam logic [3:0] CNT_MAX = 4'd15;

    typedef struct packed {
        logic        kind;
        logic [7:0]  sender_uid;
        logic [7:0]  distance_mm;
        logic [31:0] now;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] slot;
        logic [3:0] neighbor_count;
        logic [7:0] sym_id;
        logic [7:0] distance_now;
        logic [7:0] distance_before;
        logic [3:0] expired_count;
        logic       all_far;
    } out_word_t;

    // classified command handed from front to back
    typedef struct packed {
        logic        kind;
        logic        drop;
        logic [7:0]  uid;
        logic [7:0]  distance;
        logic [7:0]  sym;
        logic [31:0] now;
        logic [31:0] expiry;
    } cmd_t;

    // one table entry as held in the slot memory
    typedef struct packed {
        logic [7:0]  uid;
        logic [7:0]  sym;
        logic [7:0]  distance;
        logic [7:0]  prev;
        logic [31:0] expiry;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ===== design/ntx_ram.sv =====
module ntx_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ntx_front.sv =====
module ntx_front #(
    parameter int unsigned EMPTY_ID = 255
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  ntx_pkg::in_word_t s_data,
    input  logic [7:0]        base_uid,
    input  logic [31:0]       forget_interval,
    input  logic              q_full,
    output logic              q_push,
    output ntx_pkg::cmd_t     q_cmd
);
    import ntx_pkg::*;

    logic [32:0] exp_sum;

    // saturating expiry: now plus interval, clamp on carry
    assign exp_sum = {1'b0, s_data.now} + {1'b0, forget_interval};

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_cmd          = '0;
        q_cmd.kind     = s_data.kind;
        q_cmd.uid      = s_data.sender_uid;
        q_cmd.distance = s_data.distance_mm;
        q_cmd.now      = s_data.now;
        q_cmd.sym      = s_data.sender_uid - base_uid;
        q_cmd.drop     = (s_data.sender_uid == 8'(EMPTY_ID));
        q_cmd.expiry   = exp_sum[32] ? '1 : exp_sum[31:0];
    end

endmodule

// ===== design/ntx_queue.sv =====
module ntx_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ntx_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output ntx_pkg::cmd_t pop_cmd
);
    import ntx_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/ntx_back.sv =====
module ntx_back #(
    parameter int unsigned SLOTS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         near_threshold,
    input  logic               q_not_empty,
    input  ntx_pkg::cmd_t      q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output ntx_pkg::out_word_t m_data
);
    import ntx_pkg::*;

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH,
        S_REPORT
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CW-1:0]     rd_cnt_reg, rd_cnt_next;
    logic [IW-1:0]     chk_idx_reg, chk_idx_next;
    logic [SLOTS-1:0]  occ_reg, occ_next;
    logic [SLOTS-1:0]  near_reg, near_next;
    logic [3:0]        count_reg, count_next;
    logic [3:0]        exp_cnt_reg, exp_cnt_next;
    logic              hit_found_reg, hit_found_next;
    logic [IW-1:0]     hit_idx_reg, hit_idx_next;
    logic [7:0]        hit_dist_reg, hit_dist_next;
    logic [7:0]        hit_prev_reg, hit_prev_next;
    logic              empty_found_reg, empty_found_next;
    logic [IW-1:0]     empty_idx_reg, empty_idx_next;
    out_word_t         res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    entry_t            ram_wdata;
    logic [IW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            ent;
    logic [IW-1:0]     wr_idx;
    logic [7:0]        old_dist;
    logic [7:0]        old_prev;

    ntx_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent = entry_t'(ram_rdata);

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        rd_cnt_next      = rd_cnt_reg;
        chk_idx_next     = chk_idx_reg;
        occ_next         = occ_reg;
        near_next        = near_reg;
        count_next       = count_reg;
        exp_cnt_next     = exp_cnt_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_dist_next    = hit_dist_reg;
        hit_prev_next    = hit_prev_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        res_next         = res_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        q_pop            = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_raddr        = '0;
        wr_idx           = hit_found_reg ? hit_idx_reg : empty_idx_reg;
        old_dist         = hit_found_reg ? hit_dist_reg : 8'd0;
        old_prev         = hit_found_reg ? hit_prev_reg : 8'd0;

        // drop the output word once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (q_not_empty) begin
                    q_pop            = 1'b1;
                    cmd_next         = q_cmd;
                    ram_raddr        = '0;
                    rd_cnt_next      = CW'(1);
                    chk_idx_next     = '0;
                    hit_found_next   = 1'b0;
                    empty_found_next = 1'b0;
                    exp_cnt_next     = 4'd0;
                    state_next       = S_WALK;
                end
            end

            S_WALK: begin
                near_next[chk_idx_reg] = (ent.distance < near_threshold);
                if (cmd_reg.kind == KIND_MSG) begin
                    if (occ_reg[chk_idx_reg] && ent.uid == cmd_reg.uid && !hit_found_reg) begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = chk_idx_reg;
                        hit_dist_next  = ent.distance;
                        hit_prev_next  = ent.prev;
                    end
                    if (!occ_reg[chk_idx_reg] && !empty_found_reg) begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = chk_idx_reg;
                    end
                end else if (occ_reg[chk_idx_reg] && cmd_reg.now >= ent.expiry) begin
                    // forget this neighbour
                    occ_next[chk_idx_reg] = 1'b0;
                    if (count_reg != 4'd0) begin
                        count_next = count_reg - 4'd1;
                    end
                    if (exp_cnt_reg != CNT_MAX) begin
                        exp_cnt_next = exp_cnt_reg + 4'd1;
                    end
                end
                if (rd_cnt_reg == CW'(SLOTS)) begin
                    state_next = S_FINISH;
                end else begin
                    ram_raddr    = rd_cnt_reg[IW-1:0];
                    chk_idx_next = rd_cnt_reg[IW-1:0];
                    rd_cnt_next  = rd_cnt_reg + CW'(1);
                end
            end

            S_FINISH: begin
                res_next = '0;
                if (cmd_reg.kind == KIND_TICK) begin
                    res_next.status        = ST_SWEPT;
                    res_next.expired_count = exp_cnt_reg;
                end else begin
                    res_next.sym_id = cmd_reg.sym;
                    if (cmd_reg.drop || (!hit_found_reg && !empty_found_reg)) begin
                        res_next.status = ST_DROPPED;
                    end else begin
                        ram_wdata.uid      = cmd_reg.uid;
                        ram_wdata.sym      = cmd_reg.sym;
                        ram_wdata.distance = cmd_reg.distance;
                        ram_wdata.expiry   = cmd_reg.expiry;
                        // first distance seeds both history entries
                        if (old_dist == 8'd0 && old_prev == 8'd0) begin
                            ram_wdata.prev = cmd_reg.distance;
                        end else begin
                            ram_wdata.prev = old_dist;
                        end
                        ram_we               = 1'b1;
                        ram_waddr            = wr_idx;
                        occ_next[wr_idx]     = 1'b1;
                        near_next[wr_idx]    = (cmd_reg.distance < near_threshold);
                        if (!hit_found_reg && count_reg != CNT_MAX) begin
                            count_next = count_reg + 4'd1;
                        end
                        res_next.status          = hit_found_reg ? ST_UPDATED : ST_INSERTED;
                        res_next.slot            = 3'(wr_idx);
                        res_next.distance_now    = cmd_reg.distance;
                        res_next.distance_before = ram_wdata.prev;
                    end
                end
                state_next = S_REPORT;
            end

            S_REPORT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next                = res_reg;
                    m_data_next.neighbor_count = count_reg;
                    m_data_next.all_far        = (count_reg == 4'd0) || !(|(occ_reg & near_reg));
                    m_valid_next               = 1'b1;
                    state_next                 = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            occ_reg         <= '0;
            count_reg       <= 4'd0;
            m_valid_reg     <= 1'b0;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            rd_cnt_reg      <= '0;
        end else begin
            state_reg       <= state_next;
            occ_reg         <= occ_next;
            count_reg       <= count_next;
            m_valid_reg     <= m_valid_next;
            hit_found_reg   <= hit_found_next;
            empty_found_reg <= empty_found_next;
            rd_cnt_reg      <= rd_cnt_next;
            cmd_reg         <= cmd_next;
            chk_idx_reg     <= chk_idx_next;
            near_reg        <= near_next;
            exp_cnt_reg     <= exp_cnt_next;
            hit_idx_reg     <= hit_idx_next;
            hit_dist_reg    <= hit_dist_next;
            hit_prev_reg    <= hit_prev_next;
            empty_idx_reg   <= empty_idx_next;
            res_reg         <= res_next;
            m_data_reg      <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/neighbor_table_with_expiry.sv =====
// Each accepted word is walked over the slot memory (one read port, one slot examined per
// cycle), then written back (messages only) and reported; the next word leaves the queue
// only once that result is issued, and the report waits while an earlier result is held.
// Two words may wait in the command queue while the walk runs and a result is held.
// Reset (aresetn low, synchronous): every slot empty, neighbour count zero,
// base_uid 0, forget_interval 64, near_threshold 100; queue and output word flushed.
module neighbor_table_with_expiry #(
    parameter int unsigned SLOTS    = 8,
    parameter int unsigned EMPTY_ID = 255
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ntx_pkg::ADDR_W-1:0]   paddr,
    input  logic [ntx_pkg::DATA_W-1:0]   pwdata,
    output logic [ntx_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // input words
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ntx_pkg::in_word_t            s_data,
    // result words
    output logic                         m_valid,
    input  logic                         m_ready,
    output ntx_pkg::out_word_t           m_data
);
    import ntx_pkg::*;

    logic [7:0]  base_uid_reg, base_uid_next;
    logic [31:0] forget_interval_reg, forget_interval_next;
    logic [7:0]  near_threshold_reg, near_threshold_next;
    logic [1:0]  reg_idx;
    logic        cfg_write;

    logic        q_full;
    logic        q_push;
    cmd_t        q_push_cmd;
    logic        q_pop;
    logic        q_not_empty;
    cmd_t        q_pop_cmd;

    // Register index is the word address; writes beyond the map are ignored.
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        base_uid_next        = base_uid_reg;
        forget_interval_next = forget_interval_reg;
        near_threshold_next  = near_threshold_reg;
        prdata               = '0;
        unique case (reg_idx)
            REG_BASE_UID: begin
                prdata = {24'd0, base_uid_reg};
                if (cfg_write) begin
                    base_uid_next = pwdata[7:0];
                end
            end
            REG_FORGET_INTERVAL: begin
                prdata = forget_interval_reg;
                if (cfg_write) begin
                    forget_interval_next = pwdata;
                end
            end
            REG_NEAR_THRESHOLD: begin
                prdata = {24'd0, near_threshold_reg};
                if (cfg_write) begin
                    near_threshold_next = pwdata[7:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_uid_reg        <= RST_BASE_UID;
            forget_interval_reg <= RST_FORGET_INTERVAL;
            near_threshold_reg  <= RST_NEAR_THRESHOLD;
        end else begin
            base_uid_reg        <= base_uid_next;
            forget_interval_reg <= forget_interval_next;
            near_threshold_reg  <= near_threshold_next;
        end
    end

    // Front: take the word, form symbolic id and saturated expiry, flag the empty id.
    ntx_front #(
        .EMPTY_ID (EMPTY_ID)
    ) u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .base_uid        (base_uid_reg),
        .forget_interval (forget_interval_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (q_push_cmd)
    );

    // Two-entry queue: hold classified words while the back end walks the table.
    ntx_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (q_pop_cmd)
    );

    // Back: walk every slot, sweep or look up, write back, report.
    ntx_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .near_threshold (near_threshold_reg),
        .q_not_empty    (q_not_empty),
        .q_cmd          (q_pop_cmd),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ntx_pkg::*;

    localparam int unsigned NSLOTS     = 8;
    localparam logic [7:0]  EMPTY_UID  = 8'd255;
    localparam int unsigned QUIET_MAX  = 3000;   // cycles with no handshake before giving up
    localparam int unsigned SHOW_MAX   = 10;     // mismatches reported in full

    // ------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero
    // ------------------------------------------------------------------
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr  = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_word_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_data;

    always #5 aclk = ~aclk;

    neighbor_table_with_expiry #(
        .SLOTS    (NSLOTS),
        .EMPTY_ID (255)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the neighbour table and of the registers
    // ------------------------------------------------------------------
    logic [7:0]  cfg_base     = RST_BASE_UID;
    logic [31:0] cfg_interval = RST_FORGET_INTERVAL;
    logic [7:0]  cfg_thresh   = RST_NEAR_THRESHOLD;

    logic [7:0]  nb_uid   [NSLOTS];
    logic [7:0]  nb_sym   [NSLOTS];
    logic [7:0]  nb_dist  [NSLOTS];
    logic [7:0]  nb_prev  [NSLOTS];
    logic [31:0] nb_expiry[NSLOTS];
    logic [3:0]  nb_count = '0;

    initial begin
        for (int k = 0; k < NSLOTS; k++) begin
            nb_uid[k]    = EMPTY_UID;
            nb_sym[k]    = EMPTY_UID;
            nb_dist[k]   = '0;
            nb_prev[k]   = '0;
            nb_expiry[k] = '0;
        end
    end

    // Queues between the stimulus, the driver and the monitor
    in_word_t  pending_words[$];
    out_word_t expected_results[$];

    // Run bookkeeping
    int unsigned mismatches   = 0;
    int unsigned words_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned drops_seen   = 0;
    int unsigned forgotten    = 0;
    int unsigned settings_run = 1;
    bit          calm         = 1'b0;   // set for the final stretch: no idling at all
    logic [31:0] stim_now     = '0;     // running robot clock used to build words
    out_word_t   predicted;

    // Release a slot back to the empty state
    task automatic forget_slot(input int k);
        nb_uid[k]    = EMPTY_UID;
        nb_sym[k]    = EMPTY_UID;
        nb_dist[k]   = '0;
        nb_prev[k]   = '0;
        nb_expiry[k] = '0;
    endtask

    // Apply one word to the shadow table and work out the result word it yields
    task automatic predict_neighbour(input in_word_t w, output out_word_t r);
        int          hit;
        bit          fresh;
        bit          far;
        logic [32:0] sum;
        logic [3:0]  cleared;
        r       = '0;
        cleared = '0;
        hit     = NSLOTS;
        fresh   = 1'b0;
        far     = 1'b1;
        if (w.kind == KIND_TICK) begin
            // Sweep: drop every occupied slot whose expiry has been reached
            for (int k = 0; k < NSLOTS; k++) begin
                if (nb_uid[k] != EMPTY_UID && w.now >= nb_expiry[k]) begin
                    forget_slot(k);
                    if (nb_count != 0)
                        nb_count = nb_count - 1'b1;
                    if (cleared != CNT_MAX)
                        cleared = cleared + 1'b1;
                end
            end
            r.status        = ST_SWEPT;
            r.expired_count = cleared;
        end else begin
            r.sym_id = w.sender_uid - cfg_base;
            // The empty id can never be stored, so such a sender is dropped
            if (w.sender_uid != EMPTY_UID) begin
                for (int k = 0; k < NSLOTS; k++) begin
                    if (hit == NSLOTS && nb_uid[k] == w.sender_uid)
                        hit = k;
                end
                for (int k = 0; k < NSLOTS; k++) begin
                    if (hit == NSLOTS && nb_uid[k] == EMPTY_UID) begin
                        hit   = k;
                        fresh = 1'b1;
                    end
                end
            end
            if (hit == NSLOTS) begin
                r.status = ST_DROPPED;
            end else begin
                if (fresh && nb_count != CNT_MAX)
                    nb_count = nb_count + 1'b1;
                nb_uid[hit] = w.sender_uid;
                nb_sym[hit] = r.sym_id;
                // A slot with no history takes the first distance into both places
                if (nb_dist[hit] == 0 && nb_prev[hit] == 0) begin
                    nb_dist[hit] = w.distance_mm;
                    nb_prev[hit] = w.distance_mm;
                end else begin
                    nb_prev[hit] = nb_dist[hit];
                    nb_dist[hit] = w.distance_mm;
                end
                // Expiry saturates rather than wrapping round
                sum            = {1'b0, w.now} + {1'b0, cfg_interval};
                nb_expiry[hit] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                r.status          = fresh ? ST_INSERTED : ST_UPDATED;
                r.slot            = hit[2:0];
                r.distance_now    = nb_dist[hit];
                r.distance_before = nb_prev[hit];
            end
        end
        r.neighbor_count = nb_count;
        if (nb_count != 0) begin
            for (int k = 0; k < NSLOTS; k++) begin
                if (nb_uid[k] != EMPTY_UID && nb_dist[k] < cfg_thresh)
                    far = 1'b0;
            end
        end
        r.all_far = far;
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued words, with random bursts of idle cycles
    // ------------------------------------------------------------------
    int unsigned send_gap = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            // The word on the bus has just gone in: advance the shadow table
            if (s_valid && s_ready) begin
                predict_neighbour(s_data, predicted);
                expected_results.push_back(predicted);
                words_sent++;
            end
            // Hold the word until taken; only then move on to the next one
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    if (!calm && $urandom_range(0, 9) == 0) begin
                        send_gap <= $urandom_range(0, 14);
                        s_valid  <= 1'b0;
                    end else begin
                        s_valid <= 1'b1;
                        s_data  <= pending_words.pop_front();
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result word against the oldest prediction
    // ------------------------------------------------------------------
    int unsigned stall_left = 0;
    out_word_t   oldest;

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= SHOW_MAX)
                $display("[%0t] result %0d: %s expected %0d, got %0d",
                         $realtime, results_seen, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("[%0t] result word with nothing predicted: %p",
                                 $realtime, m_data);
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("status",          oldest.status,          m_data.status);
                    check_field("slot",            oldest.slot,            m_data.slot);
                    check_field("neighbor_count",  oldest.neighbor_count,
                                m_data.neighbor_count);
                    check_field("sym_id",          oldest.sym_id,          m_data.sym_id);
                    check_field("distance_now",    oldest.distance_now,    m_data.distance_now);
                    check_field("distance_before", oldest.distance_before,
                                m_data.distance_before);
                    check_field("expired_count",   oldest.expired_count,
                                m_data.expired_count);
                    check_field("all_far",         oldest.all_far,         m_data.all_far);
                    if (oldest.status == ST_DROPPED)
                        drops_seen++;
                    forgotten += oldest.expired_count;
                end
                results_seen++;
            end
            // Stall the result side in bursts, never in the final stretch
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(0, 14);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up when neither channel moves for too long
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("Watchdog: no word moved for %0d cycles, %0d predictions outstanding",
                     quiet_cycles, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_message(input logic [7:0] uid, input logic [7:0] dist_mm,
                                 input logic [31:0] now);
        in_word_t w;
        w.kind        = KIND_MSG;
        w.sender_uid  = uid;
        w.distance_mm = dist_mm;
        w.now         = now;
        pending_words.push_back(w);
    endtask

    task automatic queue_tick(input logic [31:0] now);
        in_word_t w;
        w.kind        = KIND_TICK;
        w.sender_uid  = 8'($urandom);
        w.distance_mm = 8'($urandom);
        w.now         = now;
        pending_words.push_back(w);
    endtask

    // Advance the robot clock: mostly small steps, now and then a long jump
    // or a leap to the top of the range where expiry saturates
    function automatic logic [31:0] next_now();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            stim_now = 32'hFFFF_FFFF - $urandom_range(0, 3);
        else if (pick < 8)
            stim_now = $urandom;
        else if (pick < 60)
            stim_now = stim_now + $urandom_range(0, 4);
        else if (pick < 92)
            stim_now = stim_now + $urandom_range(0, 120);
        else
            stim_now = stim_now + $urandom_range(0, 1000);
        return stim_now;
    endfunction

    // Mostly messages from a small crowd of robots so that the table fills,
    // repeats and empties; the rest are sweeps, stray ids and the empty id
    task automatic queue_random(input int unsigned n);
        int unsigned pick;
        logic [7:0]  uid;
        logic [7:0]  dist_mm;
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 35) begin
                queue_tick(next_now());
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    uid = cfg_base + 8'($urandom_range(0, 11));
                else if (pick < 85)
                    uid = EMPTY_UID;
                else
                    uid = 8'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    dist_mm = 8'd0;
                else if (pick < 15)
                    dist_mm = 8'hFF;
                else
                    dist_mm = 8'($urandom);
                queue_message(uid, dist_mm, next_now());
            end
        end
    endtask

    // Sample at the falling edge so the queues are never read mid-update
    task automatic wait_drained();
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    // Two-phase APB write; mirror the value once the access cycle has passed
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        case (idx)
            REG_BASE_UID:        cfg_base     = value[7:0];
            REG_FORGET_INTERVAL: cfg_interval = value;
            REG_NEAR_THRESHOLD:  cfg_thresh   = value[7:0];
            default: ;
        endcase
    endtask

    // Reprogram every register, then run a batch of random words under it
    task automatic run_setting(input logic [7:0] base, input logic [31:0] interval,
                               input logic [7:0] thresh, input int unsigned n);
        wait_drained();
        write_reg(REG_BASE_UID, {24'd0, base});
        write_reg(REG_FORGET_INTERVAL, interval);
        write_reg(REG_NEAR_THRESHOLD, {24'd0, thresh});
        settings_run++;
        queue_random(n);
    endtask

    // Result latency of the block plus a margin
    function automatic int unsigned SLOTS_LATENCY();
        return NSLOTS + 4 + 8;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under the reset values of the registers
        queue_tick(32'd0);                      // sweep of an empty table
        queue_message(8'd10, 8'd0, 32'd100);    // insert with no distance yet
        queue_message(8'd10, 8'd50, 32'd101);   // first real distance fills both
        queue_message(8'd10, 8'd200, 32'd102);  // history shifts
        queue_message(EMPTY_UID, 8'd30, 32'd103);   // empty id is dropped
        queue_message(8'd0, 8'd255, 32'd104);
        queue_message(8'd1, 8'd99, 32'd105);    // just inside the threshold
        queue_message(8'd2, 8'd100, 32'd106);   // exactly on the threshold
        queue_message(8'd3, 8'd7, 32'd107);
        queue_message(8'd4, 8'd180, 32'd108);
        queue_message(8'd5, 8'd1, 32'd109);
        queue_message(8'd254, 8'd128, 32'd110); // table now full
        queue_message(8'd77, 8'd40, 32'd111);   // unknown sender, no room
        queue_message(8'd0, 8'd0, 32'd112);     // update with zero distance
        queue_message(8'd0, 8'd60, 32'd113);
        queue_tick(32'd165);                    // nothing reached yet
        queue_tick(32'd170);                    // some slots reach expiry
        queue_message(8'd20, 8'd90, 32'hFFFF_FFF0);  // expiry saturates
        queue_tick(32'hFFFF_FFFE);
        queue_tick(32'hFFFF_FFFF);              // everything goes
        queue_message(8'd128, 8'd255, 32'hFFFF_FFFF);
        queue_message(8'd128, 8'd0, 32'd0);
        queue_tick(32'd0);
        stim_now = 32'd200;
        queue_random(110);

        // Extremes of every register, including a zero interval
        run_setting(8'd255, 32'd1, 8'd0, 130);
        run_setting(8'd0, 32'hFFFF_FFFF, 8'd255, 130);
        run_setting(8'($urandom), 32'd0, 8'($urandom), 130);
        run_setting(8'($urandom), 32'($urandom_range(2, 300)), 8'($urandom), 130);
        run_setting(8'($urandom), 32'($urandom), 8'($urandom_range(50, 200)), 130);

        // Last stretch: back to the reset values, both sides flat out
        wait_drained();
        calm = 1'b1;
        run_setting(RST_BASE_UID, RST_FORGET_INTERVAL, RST_NEAR_THRESHOLD, 60);

        // Drain, then allow the pipeline depth again before judging
        wait_drained();
        repeat (SLOTS_LATENCY()) @(negedge aclk);
        if (expected_results.size() != 0) begin
            mismatches += expected_results.size();
            $display("%0d predicted results never arrived", expected_results.size());
        end

        $display("Covered %0d words under %0d register settings: %0d results checked,",
                 words_sent, settings_run, results_seen);
        $display("%0d messages dropped, %0d neighbours forgotten by sweeps, %0d mismatches",
                 drops_seen, forgotten, mismatches);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
